[hw/rtl/synthetic_loss_reply_tracker_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the reply tracker modules
// ---------------------------------------------------------------------------
`ifndef SYNTHETIC_LOSS_REPLY_TRACKER_UNIT_ASSERT_SVH
`define SYNTHETIC_LOSS_REPLY_TRACKER_UNIT_ASSERT_SVH

// Implication or plain property, checked on clk_i, quiet while in reset
`define SLRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen
`define SLRT_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[hw/rtl/slrt_pkg.sv]
// ---------------------------------------------------------------------------
// slrt_pkg
// Types, constants and status codes of the synthetic-loss reply tracker.
// ---------------------------------------------------------------------------
package slrt_pkg;

  localparam int unsigned PEER_SLOTS = 16;
  localparam int unsigned SLOT_W     = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(PEER_SLOTS + 1);
  localparam int unsigned SLOT_EXT_W = (SLOT_W > 4) ? SLOT_W : 4;

  localparam int unsigned MAC_W    = 48;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [15:0] MIN_RESPONDER = 16'd1;
  localparam logic [15:0] MAX_RESPONDER = 16'd8191;
  localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SEC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LATE_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OAM_ETYPE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_OPC   = 3'd4;

  localparam logic [7:0]  LATE_LIMIT_RESET = 8'd5;
  localparam logic [15:0] OAM_ETYPE_RESET  = 16'h8902;
  localparam logic [7:0]  REPLY_OPC_RESET  = 8'd54;

  // result status codes
  localparam logic [2:0] STATUS_COUNTED   = 3'd0;
  localparam logic [2:0] STATUS_REPORT    = 3'd1;
  localparam logic [2:0] STATUS_LATE      = 3'd2;
  localparam logic [2:0] STATUS_BAD_ETYPE = 3'd3;
  localparam logic [2:0] STATUS_OWN       = 3'd4;
  localparam logic [2:0] STATUS_NOT_REPLY = 3'd5;
  localparam logic [2:0] STATUS_BAD_ID    = 3'd6;
  localparam logic [2:0] STATUS_FULL      = 3'd7;

  typedef struct packed {
    logic        reject;
    logic [2:0]  status;
  } screen_t;

  typedef struct packed {
    logic [31:0] window_seconds;
    logic [7:0]  late_limit;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [MAC_W-1:0] src;
  } search_req_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic              free;
    logic [SLOT_W-1:0] slot;
  } search_rsp_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [MAC_W-1:0]  mac;
  } insert_t;

  typedef struct packed {
    logic [12:0] peer_id;
    logic [2:0]  peer_level;
    logic [31:0] count;
    logic        open;
    logic [31:0] first_fwd;
    logic [31:0] first_bwd;
    logic [31:0] start_rx;
    logic [31:0] win_start;
  } entry_t;

endpackage

[hw/rtl/slrt_ram.sv]
// ---------------------------------------------------------------------------
// slrt_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module slrt_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/slrt_cfg_regs.sv]
// ---------------------------------------------------------------------------
// slrt_cfg_regs
// Configuration registers and the header screen of a received reply.
// ---------------------------------------------------------------------------
module slrt_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [slrt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [slrt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [slrt_pkg::MAC_W-1:0]       src_i,
  input  logic [15:0]                      etype_i,
  input  logic [7:0]                       opcode_i,
  input  logic [15:0]                      rid_i,
  output slrt_pkg::screen_t                screen_o,
  output slrt_pkg::cfg_t                   cfg_o
);
  import slrt_pkg::*;

  logic [MAC_W-1:0] own_mac_q;
  logic [31:0]      window_q;
  logic [7:0]       late_q;
  logic [15:0]      etype_q;
  logic [7:0]       opc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      window_q  <= '0;
      late_q    <= LATE_LIMIT_RESET;
      etype_q   <= OAM_ETYPE_RESET;
      opc_q     <= REPLY_OPC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OWN_MAC:    own_mac_q <= cfg_wdata_i[MAC_W-1:0];
        CFG_WINDOW_SEC: window_q  <= cfg_wdata_i[31:0];
        CFG_LATE_LIMIT: late_q    <= cfg_wdata_i[7:0];
        CFG_OAM_ETYPE:  etype_q   <= cfg_wdata_i[15:0];
        CFG_REPLY_OPC:  opc_q     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // checks in priority order: ethertype, own address, opcode, responder id
  always_comb begin
    screen_o.reject = 1'b1;
    screen_o.status = STATUS_COUNTED;
    if (etype_i != etype_q) begin
      screen_o.status = STATUS_BAD_ETYPE;
    end else if (src_i == own_mac_q) begin
      screen_o.status = STATUS_OWN;
    end else if (opcode_i != opc_q) begin
      screen_o.status = STATUS_NOT_REPLY;
    end else if (rid_i < MIN_RESPONDER || rid_i > MAX_RESPONDER) begin
      screen_o.status = STATUS_BAD_ID;
    end else begin
      screen_o.reject = 1'b0;
    end
  end

  assign cfg_o.window_seconds = window_q;
  assign cfg_o.late_limit     = late_q;

endmodule

[hw/rtl/slrt_peer_search.sv]
// ---------------------------------------------------------------------------
// slrt_peer_search
// Peer address memory and valid bits; walks the table one entry a cycle to
// find the matching peer or the lowest free entry.
// ---------------------------------------------------------------------------
`include "synthetic_loss_reply_tracker_unit_assert.svh"

module slrt_peer_search (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slrt_pkg::search_req_t req_i,
  input  slrt_pkg::insert_t     ins_i,
  output slrt_pkg::search_rsp_t rsp_o
);
  import slrt_pkg::*;

  logic [PEER_SLOTS-1:0] valid_q;
  logic                  active_q;
  logic [CNT_W-1:0]      scan_q;
  logic                  pend_q;
  logic [SLOT_W-1:0]     pend_idx_q;
  logic                  hit_q, free_q;
  logic [SLOT_W-1:0]     hit_idx_q, free_idx_q;
  search_rsp_t           rsp_q;

  logic                  rd_en;
  logic [MAC_W-1:0]      mac_rdata;
  logic                  match, empty;

  assign rd_en = active_q && (scan_q != CNT_W'(PEER_SLOTS));

  slrt_ram #(
    .WIDTH (MAC_W),
    .DEPTH (PEER_SLOTS)
  ) u_mac_ram (
    .clk_i   (clk_i),
    .we_i    (ins_i.en),
    .waddr_i (ins_i.slot),
    .wdata_i (ins_i.mac),
    .re_i    (rd_en),
    .raddr_i (scan_q[SLOT_W-1:0]),
    .rdata_o (mac_rdata)
  );

  assign match = pend_q && valid_q[pend_idx_q] && (mac_rdata == req_i.src);
  assign empty = pend_q && !valid_q[pend_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      active_q   <= 1'b0;
      scan_q     <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      rsp_q      <= '0;
    end else begin
      rsp_q.done <= 1'b0;
      if (ins_i.en) begin
        valid_q[ins_i.slot] <= 1'b1;
      end
      if (req_i.start) begin
        active_q <= 1'b1;
        scan_q   <= '0;
        pend_q   <= 1'b0;
        hit_q    <= 1'b0;
        free_q   <= 1'b0;
      end else if (active_q) begin
        pend_q     <= rd_en;
        pend_idx_q <= scan_q[SLOT_W-1:0];
        if (rd_en) begin
          scan_q <= scan_q + CNT_W'(1);
        end
        // keep the first hit and the lowest free entry
        if (match && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= pend_idx_q;
        end
        if (empty && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= pend_idx_q;
        end
        if (!rd_en) begin
          active_q   <= 1'b0;
          rsp_q.done <= 1'b1;
          rsp_q.hit  <= hit_q || match;
          rsp_q.free <= free_q || empty;
          if (hit_q) begin
            rsp_q.slot <= hit_idx_q;
          end else if (match) begin
            rsp_q.slot <= pend_idx_q;
          end else if (free_q) begin
            rsp_q.slot <= free_idx_q;
          end else begin
            rsp_q.slot <= pend_idx_q;
          end
        end
      end
    end
  end

  assign rsp_o = rsp_q;

  `SLRT_ASSERT(a_done_ends_scan, rsp_q.done |-> !active_q, "search done while still scanning")
  `SLRT_ASSERT(a_hit_is_valid, (rsp_q.done && rsp_q.hit) |-> valid_q[rsp_q.slot],
               "hit reported on an empty entry")
  `SLRT_ASSERT(a_free_is_empty, (rsp_q.done && !rsp_q.hit && rsp_q.free) |-> !valid_q[rsp_q.slot],
               "free entry reported on a used entry")
  `SLRT_ASSERT_NEVER(a_start_while_active, req_i.start && active_q,
                     "search started while a scan is running")

endmodule

[hw/rtl/synthetic_loss_reply_tracker_unit.sv]
// ---------------------------------------------------------------------------
// synthetic_loss_reply_tracker_unit
// Tracks synthetic-loss replies per peer and reports frame loss per window.
// ---------------------------------------------------------------------------
// Usage:
//   Configuration: write cfg_wdata_i to register cfg_index_i while cfg_we_i is
//   high (0 own address, 1 window, 2 late limit, 3 ethertype, 4 opcode).
//   Input: one reply beat is taken at a rising edge with start high and busy
//   low; busy stays high until the result beat has been produced.
//   Output: done_o is high for exactly one cycle with status, losses and
//   slot; the receiver cannot stall, so each result must be taken then.
//   Sequence: a screened-out frame gives its result straight from the check
//   state. Any other frame walks the peer address memory one entry per
//   cycle; a full table then gives its result, else the frame reads, updates
//   and writes back its entry record before the result shows. A new beat
//   can be taken in the cycle the result is shown.
//   Reset: clears all valid bits and loads the register defaults; no table
//   sweep is needed, the block is ready as soon as reset is released.
// ---------------------------------------------------------------------------
`include "synthetic_loss_reply_tracker_unit_assert.svh"

module synthetic_loss_reply_tracker_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [slrt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [slrt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [47:0]                      source_mac_i,
  input  logic [15:0]                      frame_ethertype_i,
  input  logic [7:0]                       frame_opcode_i,
  input  logic [2:0]                       level_i,
  input  logic [15:0]                      responder_id_i,
  input  logic [31:0]                      forward_count_i,
  input  logic [31:0]                      backward_count_i,
  input  logic [31:0]                      now_seconds_i,
  input  logic [31:0]                      request_sent_seconds_i,
  output logic                             done_o,
  output logic [2:0]                       status_o,
  output logic signed [32:0]               far_loss_o,
  output logic signed [32:0]               near_loss_o,
  output logic [3:0]                       peer_slot_o
);
  import slrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_ENTRY,
    S_EVAL,
    S_OUT
  } state_e;

  state_e state_q;

  // captured reply beat
  logic [MAC_W-1:0] src_q;
  logic [15:0]      etype_q;
  logic [7:0]       opc_q;
  logic [2:0]       lvl_q;
  logic [15:0]      rid_q;
  logic [31:0]      fwd_q, bwd_q, now_q, sent_q;

  logic              late_q, insert_q, report_q;
  logic [SLOT_W-1:0] slot_q;
  entry_t            rec_q;
  logic [31:0]       dfwd_q, dbwd_q, drx_q;
  logic [2:0]        res_status_q;

  logic              done_q;
  logic [2:0]        status_q;
  logic [32:0]       far_q, near_q;
  logic [3:0]        slot_out_q;

  screen_t       screen;
  cfg_t          cfg;
  search_req_t   sreq;
  search_rsp_t   srsp;
  insert_t       ins;
  entry_t        ent_rdata, rec_d, rec_wb;
  logic          accept, elapsed, report;
  logic [SLOT_EXT_W-1:0] slot_ext;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  slrt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .src_i       (src_q),
    .etype_i     (etype_q),
    .opcode_i    (opc_q),
    .rid_i       (rid_q),
    .screen_o    (screen),
    .cfg_o       (cfg)
  );

  assign sreq.start = (state_q == S_CHECK) && !screen.reject;
  assign sreq.src   = src_q;

  assign ins.en   = (state_q == S_EVAL) && insert_q;
  assign ins.slot = slot_q;
  assign ins.mac  = src_q;

  slrt_peer_search u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sreq),
    .ins_i  (ins),
    .rsp_o  (srsp)
  );

  slrt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (PEER_SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_EVAL),
    .waddr_i (slot_q),
    .wdata_i (rec_wb),
    .re_i    (srsp.done),
    .raddr_i (srsp.slot),
    .rdata_o (ent_rdata)
  );

  // count the reply, and open a window if none is open
  always_comb begin
    rec_d = ent_rdata;
    if (insert_q) begin
      rec_d.peer_id    = rid_q[12:0];
      rec_d.peer_level = lvl_q;
      rec_d.count      = 32'd1;
      rec_d.open       = 1'b0;
    end else if (ent_rdata.count == COUNT_MAX) begin
      rec_d.count = 32'd1;
    end else begin
      rec_d.count = ent_rdata.count + 32'd1;
    end
    if (!rec_d.open) begin
      rec_d.open      = 1'b1;
      rec_d.first_fwd = fwd_q;
      rec_d.first_bwd = bwd_q;
      rec_d.start_rx  = rec_d.count;
      rec_d.win_start = now_q;
    end
  end

  assign elapsed = (now_q - rec_q.win_start) >= cfg.window_seconds;
  assign report  = !late_q && elapsed;

  // close the window after a report
  always_comb begin
    rec_wb = rec_q;
    if (report) begin
      rec_wb.open      = 1'b0;
      rec_wb.win_start = '0;
    end
  end

  assign slot_ext = SLOT_EXT_W'(slot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      done_q       <= 1'b0;
      status_q     <= STATUS_COUNTED;
      far_q        <= '0;
      near_q       <= '0;
      slot_out_q   <= '0;
      late_q       <= 1'b0;
      insert_q     <= 1'b0;
      report_q     <= 1'b0;
      res_status_q <= STATUS_COUNTED;
      slot_q       <= '0;
      rec_q        <= '0;
      dfwd_q       <= '0;
      dbwd_q       <= '0;
      drx_q        <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          late_q <= (now_q - sent_q) > {24'd0, cfg.late_limit};
          if (screen.reject) begin
            done_q     <= 1'b1;
            status_q   <= screen.status;
            far_q      <= '0;
            near_q     <= '0;
            slot_out_q <= '0;
            state_q    <= S_IDLE;
          end else begin
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (srsp.done) begin
            if (!srsp.hit && !srsp.free) begin
              done_q     <= 1'b1;
              status_q   <= STATUS_FULL;
              far_q      <= '0;
              near_q     <= '0;
              slot_out_q <= '0;
              state_q    <= S_IDLE;
            end else begin
              slot_q   <= srsp.slot;
              insert_q <= !srsp.hit;
              state_q  <= S_ENTRY;
            end
          end
        end
        S_ENTRY: begin
          rec_q   <= rec_d;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          dfwd_q   <= fwd_q - rec_q.first_fwd;
          dbwd_q   <= bwd_q - rec_q.first_bwd;
          drx_q    <= rec_q.count - rec_q.start_rx;
          report_q <= report;
          if (late_q) begin
            res_status_q <= STATUS_LATE;
          end else if (elapsed) begin
            res_status_q <= STATUS_REPORT;
          end else begin
            res_status_q <= STATUS_COUNTED;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          done_q     <= 1'b1;
          status_q   <= res_status_q;
          slot_out_q <= slot_ext[3:0];
          if (report_q) begin
            far_q  <= {1'b0, dfwd_q} - {1'b0, dbwd_q};
            near_q <= {1'b0, dbwd_q} - {1'b0, drx_q};
          end else begin
            far_q  <= '0;
            near_q <= '0;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // capture the beat; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q   <= source_mac_i;
      etype_q <= frame_ethertype_i;
      opc_q   <= frame_opcode_i;
      lvl_q   <= level_i;
      rid_q   <= responder_id_i;
      fwd_q   <= forward_count_i;
      bwd_q   <= backward_count_i;
      now_q   <= now_seconds_i;
      sent_q  <= request_sent_seconds_i;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign far_loss_o  = $signed(far_q);
  assign near_loss_o = $signed(near_q);
  assign peer_slot_o = slot_out_q;

  `SLRT_ASSERT(a_strobe_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `SLRT_ASSERT(a_accept_busy, accept |=> busy, "accepted beat did not raise busy")
  `SLRT_ASSERT(a_loss_zero, (done_o && status_o != STATUS_REPORT) |->
               (far_q == '0 && near_q == '0), "loss set on a result that is no report")
  `SLRT_ASSERT(a_reject_slot, (done_o && (status_o == STATUS_BAD_ETYPE ||
               status_o == STATUS_OWN || status_o == STATUS_NOT_REPLY ||
               status_o == STATUS_BAD_ID || status_o == STATUS_FULL)) |->
               peer_slot_o == 4'd0, "rejected frame carries a slot")

endmodule
